[rtl/core/wgmt_pkg.sv]
// ----------------------------------------------------------------------------
// wgmt_pkg: shared types, constants and tables for the weighted geomean block
// Holds the sequencer state type, field widths, the accumulator floor and the
// log2 and power-of-two fraction tables, which are built at elaboration.
// ----------------------------------------------------------------------------
package wgmt_pkg;

	// Field widths
	localparam int ScoreW   = 17;
	localparam int WeightW  = 16;
	localparam int MuW      = 17;
	localparam int AccW     = 27;
	localparam int NlogW    = 21;
	localparam int MagW     = NlogW + WeightW;
	localparam int TermW    = MagW - 14;

	// Term limit per set and its counter width
	localparam int MaxTerms = 16;
	localparam int CntW     = $clog2(MaxTerms + 1);

	// Go threshold after reset: 0.9995 in Q1.16
	localparam logic [MuW-1:0] ThrReset = 17'd65503;

	// Accumulator floor: -2^26 in Q10.16
	localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOG,
		ST_MUL,
		ST_ACC,
		ST_POW,
		ST_OUT
	} state_t;

	// Fraction table type
	typedef logic [16:0] tbl_t [256];

	// Integer square root, used only while building the power table.
	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] bitv;
		v = v_in;
		r = 64'd0;
		for (int k = 31; k >= 0; k--) begin
			bitv = 64'd1 << (2 * k);
			if (v >= r + bitv) begin
				v = v - (r + bitv);
				r = (r >> 1) + bitv;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	// Table of round(65536 * log2(1 + i/256)) by repeated squaring.
	function automatic tbl_t build_log_tbl();
		tbl_t t;
		logic [63:0] x;
		logic [31:0] r;
		for (int i = 0; i < 256; i++) begin
			x = 64'(256 + i) << 22;
			r = 32'd0;
			for (int k = 0; k < 24; k++) begin
				x = (x * x) >> 30;
				if (x >= (64'd1 << 31)) begin
					r = (r << 1) | 32'd1;
					x = x >> 1;
				end else begin
					r = r << 1;
				end
			end
			t[i] = 17'((r + 32'd128) >> 8);
		end
		return t;
	endfunction

	// Table of round(65536 * 2^(i/256)) from successive square roots of two.
	function automatic tbl_t build_pow_tbl();
		tbl_t t;
		logic [63:0] root;
		logic [63:0] prod;
		for (int i = 0; i < 256; i++) begin
			root = 64'd2 << 30;
			prod = 64'd1 << 30;
			for (int k = 7; k >= 0; k--) begin
				root = isqrt64(root << 30);
				if (((i >> k) & 1) != 0) begin
					prod = (prod * root) >> 30;
				end
			end
			t[i] = 17'((prod + (64'd1 << 13)) >> 14);
		end
		return t;
	endfunction

	localparam tbl_t LogTbl = build_log_tbl();
	localparam tbl_t PowTbl = build_pow_tbl();

endpackage

[rtl/core/weighted_geomean_threshold_top.sv]
// An item that is not last passes the accept, log2, multiply and accumulate steps
// before the next can be accepted, since s_tready is high only while idle; a last
// item then passes the power and output steps, and its result enters the output
// register once an earlier result, if still held, is taken. Items beyond the term
// limit skip the log2, multiply and accumulate steps; a last one still reports.
// Reset (arst_n low, asynchronous) clears the set state and output valid, loads the threshold.
// ----------------------------------------------------------------------------
// weighted_geomean_threshold_top: weighted geometric mean with go/halt decision
// Sums weight * log2(score) in a saturating log-domain accumulator and, on the
// last item of a set, emits mu = 2^acc together with the go decision.
// ----------------------------------------------------------------------------
module weighted_geomean_threshold_top (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: go threshold
	input  logic        cfg_wen,
	input  logic [16:0] cfg_wdata,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [16:0] score, [32:17] weight, [39:33] zero
	input  logic        s_tuser,   // [0] interlocks_ok
	input  logic        s_tlast,   // last_item
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [16:0] mu, [23:17] zero
	output logic        m_tuser    // [0] go
);

	wgmt_pkg::state_t state_q, state_d;

	logic [wgmt_pkg::ScoreW-1:0]  score_q;
	logic [wgmt_pkg::WeightW-1:0] weight_q;
	logic                         ok_q;
	logic                         last_q;
	logic [wgmt_pkg::MuW-1:0]     thr_q;
	logic [wgmt_pkg::CntW-1:0]    cnt_q;
	logic signed [wgmt_pkg::AccW-1:0] acc_q;
	logic [wgmt_pkg::NlogW-1:0]   nlog_q;
	logic [wgmt_pkg::MagW-1:0]    mag_q;
	logic [16:0]                  e_q;
	logic [10:0]                  q_q;
	logic [wgmt_pkg::MuW-1:0]     mu_q;
	logic                         go_q;
	logic                         out_vld_q;

	logic in_acc;
	logic out_free;
	logic room_ok;

	assign s_tready = (state_q == wgmt_pkg::ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;
	assign room_ok  = (cnt_q < wgmt_pkg::CntW'(wgmt_pkg::MaxTerms));

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'd0, mu_q};
	assign m_tuser  = go_q;

	// Negated log2 of the clamped score, from the leading-one position and table fraction.
	logic [16:0] clamp;
	logic [4:0]  lz_pos;
	logic [16:0] norm;
	logic [8:0]  lidx;
	logic [4:0]  lpos;
	logic [7:0]  ltix;
	logic [wgmt_pkg::NlogW-1:0] nlog_d;

	always_comb begin
		if (score_q == 17'd0) begin
			clamp = 17'd1;
		end else if (score_q > 17'd65536) begin
			clamp = 17'd65536;
		end else begin
			clamp = score_q;
		end
		lz_pos = 5'd0;
		for (int i = 0; i < 17; i++) begin
			if (clamp[i]) begin
				lz_pos = 5'(i);
			end
		end
		norm = clamp << (5'd16 - lz_pos);
		lidx = 9'(({1'b0, norm[15:0]} + 17'd128) >> 8);
		if (lidx[8]) begin
			ltix = 8'd0;
			lpos = lz_pos + 5'd1;
		end else begin
			ltix = lidx[7:0];
			lpos = lz_pos;
		end
		nlog_d = {5'd16 - lpos, 16'd0} - {4'd0, wgmt_pkg::LogTbl[ltix]};
	end

	// Rounded term and saturating subtract from the accumulator.
	logic [wgmt_pkg::MagW:0]      mag_rnd;
	logic [wgmt_pkg::TermW-1:0]   term;
	logic [wgmt_pkg::AccW:0]      room;
	logic signed [wgmt_pkg::AccW-1:0] acc_d;

	always_comb begin
		mag_rnd = {1'b0, mag_q} + (wgmt_pkg::MagW + 1)'(16384);
		term    = mag_rnd[wgmt_pkg::MagW:15];
		room    = {acc_q[wgmt_pkg::AccW-1], acc_q} - {wgmt_pkg::AccMin[wgmt_pkg::AccW-1],
			wgmt_pkg::AccMin};
		if ({{(wgmt_pkg::AccW + 1 - wgmt_pkg::TermW){1'b0}}, term} > room) begin
			acc_d = wgmt_pkg::AccMin;
		end else begin
			acc_d = acc_q - $signed({{(wgmt_pkg::AccW - wgmt_pkg::TermW){1'b0}}, term});
		end
	end

	// Power of two: split -acc into whole and fractional parts, pick table entry.
	logic [26:0] amag;
	logic [10:0] pq;
	logic [16:0] pf;
	logic [8:0]  pidx;
	logic [10:0] q_d;
	logic [7:0]  ptix;

	always_comb begin
		amag = 27'(-acc_q);
		pq   = amag[26:16];
		pf   = 17'd0;
		if (amag[15:0] != 16'd0) begin
			pq = pq + 11'd1;
			pf = 17'd65536 - {1'b0, amag[15:0]};
		end
		pidx = 9'((pf + 17'd128) >> 8);
		if (pidx[8]) begin
			ptix = 8'd0;
			q_d  = pq - 11'd1;
		end else begin
			ptix = pidx[7:0];
			q_d  = pq;
		end
	end

	// Final right shift of the table entry, rounded half up.
	logic [17:0] shr_sum;
	logic [wgmt_pkg::MuW-1:0] mu_d;

	always_comb begin
		shr_sum = 18'd0;
		if (q_q == 11'd0) begin
			mu_d = e_q;
		end else if (q_q > 11'd17) begin
			mu_d = 17'd0;
		end else begin
			shr_sum = ({1'b0, e_q} + (18'd1 << (q_q[4:0] - 5'd1))) >> q_q[4:0];
			mu_d    = shr_sum[16:0];
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			wgmt_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (room_ok) begin
						state_d = wgmt_pkg::ST_LOG;
					end else if (s_tlast) begin
						state_d = wgmt_pkg::ST_POW;
					end
				end
			end
			wgmt_pkg::ST_LOG: begin
				state_d = wgmt_pkg::ST_MUL;
			end
			wgmt_pkg::ST_MUL: begin
				state_d = wgmt_pkg::ST_ACC;
			end
			wgmt_pkg::ST_ACC: begin
				state_d = last_q ? wgmt_pkg::ST_POW : wgmt_pkg::ST_IDLE;
			end
			wgmt_pkg::ST_POW: begin
				state_d = wgmt_pkg::ST_OUT;
			end
			wgmt_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = wgmt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wgmt_pkg::ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wgmt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: threshold, accumulator, term count, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= wgmt_pkg::ThrReset;
			acc_q     <= '0;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				thr_q <= cfg_wdata;
			end
			if (state_q == wgmt_pkg::ST_ACC) begin
				acc_q <= acc_d;
				cnt_q <= cnt_q + wgmt_pkg::CntW'(1);
			end
			if (state_q == wgmt_pkg::ST_OUT && out_free) begin
				out_vld_q <= 1'b1;
				acc_q     <= '0;
				cnt_q     <= '0;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			score_q  <= s_tdata[16:0];
			weight_q <= s_tdata[32:17];
			ok_q     <= s_tuser;
			last_q   <= s_tlast;
		end
		if (state_q == wgmt_pkg::ST_LOG) begin
			nlog_q <= nlog_d;
		end
		if (state_q == wgmt_pkg::ST_MUL) begin
			mag_q <= nlog_q * weight_q;
		end
		if (state_q == wgmt_pkg::ST_POW) begin
			e_q <= wgmt_pkg::PowTbl[ptix];
			q_q <= q_d;
		end
		if (state_q == wgmt_pkg::ST_OUT && out_free) begin
			mu_q <= mu_d;
			go_q <= (mu_d >= thr_q) && ok_q;
		end
	end

`ifndef SYNTHESIS
	// The log accumulator never goes above zero.
	a_acc_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		!acc_q[wgmt_pkg::AccW-1] |-> acc_q == '0)
		else $error("log accumulator positive");

	// The term count never passes the limit.
	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= wgmt_pkg::CntW'(wgmt_pkg::MaxTerms))
		else $error("term count above limit");

	// A result is only formed for a last item.
	a_pow_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wgmt_pkg::ST_POW |-> last_q)
		else $error("power step without last item");

	// A go result always meets the threshold and mu never exceeds 1.0.
	a_go_thr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[16:0] <= 17'd65536) && (!m_tuser || m_tdata[16:0] >= thr_q))
		else $error("result mu or go out of range");

	// Writing a result clears the set state on the next cycle.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wgmt_pkg::ST_OUT && out_free |=> acc_q == '0 && cnt_q == '0 && m_tvalid)
		else $error("set state not cleared after result");
`endif

endmodule

[dv/tb_weighted_geomean_threshold_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_geomean_threshold_top: stream test of the weighted geomean block
// Walks a short table of directed requests, then runs phases of random sets
// under changing go thresholds and idle patterns. Each result is compared with
// a typed directed value or an in-bench log-domain accumulator and power predictor.
// ----------------------------------------------------------------------------
module tb_weighted_geomean_threshold_top;

	localparam int        TERM_LIMIT   = 16;
	localparam int        THR_AT_RESET = 65503;
	localparam longint    ACC_FLOOR    = -(64'sd1 <<< 26);
	localparam int        DRAIN_CYCLES = 12;
	localparam int        PHASE_COUNT  = 7;
	localparam int        PHASE_ITEMS  = 100;
	localparam int        LONG_HOLD    = 400;
	localparam longint    LIMIT_CYCLES = 500000;

	typedef struct packed {
		logic [16:0] mu;
		logic        go;
	} mean_result_t;

	// One directed row: repeat count, request fields and optional typed result.
	typedef struct packed {
		logic [4:0]  rep;
		logic [16:0] score;
		logic [15:0] weight;
		logic        ok;
		logic        last;
		logic        typed;
		logic [16:0] mu;
		logic        go;
	} dir_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_wen   = 1'b0;
	logic [16:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata   = '0;   // [16:0] score, [32:17] weight, [39:33] zero
	logic        s_tuser   = 1'b0; // [0] interlocks_ok
	logic        s_tlast   = 1'b0; // last_item
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;          // [16:0] mu, [23:17] zero
	logic        m_tuser;          // [0] go

	// Predictor state and tables
	logic [16:0]  log_frac [256];
	logic [16:0]  pow_frac [256];
	longint       acc_log     = 0;
	int           terms_taken = 0;
	logic [16:0]  go_thr      = 17'(THR_AT_RESET);
	mean_result_t means_due[$];

	// Idle control and bookkeeping
	int     src_idle_pct    = 0;
	int     sink_stall_pct  = 0;
	int     hold_req_cycles = 0;
	int     hold_req_seq    = 0;
	int     hold_seen       = 0;
	int     hold_left       = 0;
	int     fail_cnt        = 0;
	int     n_requests      = 0;
	int     n_sets          = 0;
	int     n_results       = 0;
	longint cycle_cnt       = 0;

	dir_row_t dir_rows [11] = '{
		// Score of exactly 1.0 gives mu of 1.0.
		'{5'd1, 17'd65536, 16'd65535, 1'b1, 1'b1, 1'b1, 17'd65536, 1'b1},
		// Zero weight with a zero score: the score is clamped to one LSB but the term is zero.
		'{5'd1, 17'd0, 16'd0, 1'b1, 1'b1, 1'b1, 17'd65536, 1'b1},
		// Score above 1.0 is clamped to 1.0.
		'{5'd1, 17'd131071, 16'd65535, 1'b1, 1'b1, 1'b1, 17'd65536, 1'b1},
		// Interlocks open force halt.
		'{5'd1, 17'd65536, 16'd0, 1'b0, 1'b1, 1'b1, 17'd65536, 1'b0},
		// Smallest score at full weight drives mu to zero.
		'{5'd1, 17'd1, 16'd65535, 1'b1, 1'b1, 1'b1, 17'd0, 1'b0},
		// Score 0.5 at weight 1.0 gives exactly 0.5, below the threshold.
		'{5'd1, 17'd32768, 16'd32768, 1'b1, 1'b1, 1'b1, 17'd32768, 1'b0},
		// A three-term set; the last score rounds its log index up into the next octave.
		'{5'd1, 17'd46341, 16'd65535, 1'b1, 1'b0, 1'b0, 17'd0, 1'b0},
		'{5'd1, 17'd12345, 16'd1, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
		'{5'd1, 17'd65535, 16'd1, 1'b1, 1'b1, 1'b0, 17'd0, 1'b0},
		// Sixteen zero-weight terms fill the term limit ...
		'{5'd16, 17'd0, 16'd0, 1'b1, 1'b0, 1'b0, 17'd0, 1'b0},
		// ... so a heavy seventeenth term is dropped, yet the set still reports.
		'{5'd1, 17'd1, 16'd65535, 1'b1, 1'b1, 1'b1, 17'd65536, 1'b1}
	};

	weighted_geomean_threshold_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #5 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side ready: random stalls, or a long hold when one is requested.
	always @(posedge clk) begin
		if (hold_req_seq != hold_seen) begin
			hold_seen <= hold_req_seq;
			hold_left <= hold_req_cycles;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= (arst_n && $urandom_range(99) >= sink_stall_pct);
		end
	end

	// Compare each delivered result with the oldest predicted mean.
	always @(posedge clk) begin
		mean_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (means_due.size() == 0) begin
				$error("result with no request pending: mu %0d go %0d", m_tdata[16:0], m_tuser);
				fail_cnt++;
			end else begin
				want = means_due.pop_front();
				if (m_tdata[16:0] !== want.mu) begin
					$error("mu: expected %0d, actual %0d", want.mu, m_tdata[16:0]);
					fail_cnt++;
				end
				if (m_tuser !== want.go) begin
					$error("go: expected %0d, actual %0d", want.go, m_tuser);
					fail_cnt++;
				end
			end
		end
	end

	// Predictor: take one request into the log accumulator and, on the last
	// request of a set, form mu = 2^acc and the go decision.
	task automatic take_term(input logic [16:0] sc, input logic [15:0] wt, input logic ok,
			input logic lst, output bit has_res, output mean_result_t res);
		longint s, frac, idx, nlog, t, a, q, r, f, e, mu;
		int p;
		has_res = 1'b0;
		res     = '0;
		if (terms_taken < TERM_LIMIT) begin
			// Clamp to [1 LSB, 1.0] and find log2 from the leading one and table.
			s = sc;
			if (s < 1) s = 1;
			if (s > 65536) s = 65536;
			p = 16;
			while (((s >> p) & 1) == 0 && p > 0) p--;
			frac = ((s << (16 - p)) - 65536) & 64'hFFFF;
			idx  = (frac + 128) >> 8;
			if (idx == 256) begin
				idx = 0;
				p++;
			end
			nlog = longint'(16 - p) * 65536 - longint'(log_frac[idx]);
			t    = (nlog * longint'(wt) + 16384) >> 15;
			terms_taken++;
			if (t > acc_log - ACC_FLOOR) acc_log = ACC_FLOOR;
			else acc_log = acc_log - t;
		end
		if (!lst) return;

		// Power of two: split into whole shift and rounded table fraction.
		a = -acc_log;
		q = a >> 16;
		r = a & 64'hFFFF;
		f = 0;
		if (r != 0) begin
			q++;
			f = 65536 - r;
		end
		idx = (f + 128) >> 8;
		if (idx == 256) begin
			idx = 0;
			q--;
		end
		e = pow_frac[idx];
		if (q == 0) mu = e;
		else if (q > 17) mu = 0;
		else mu = (e + (64'sd1 <<< (q - 1))) >> q;
		res.mu      = mu[16:0];
		res.go      = (mu >= longint'(go_thr)) && ok;
		has_res     = 1'b1;
		acc_log     = 0;
		terms_taken = 0;
	endtask

	// Offer one request, with random idle cycles first, and record its result.
	task automatic offer(input logic [16:0] sc, input logic [15:0] wt, input logic ok,
			input logic lst, input logic typed, input logic [16:0] tmu, input logic tgo);
		bit           has_res;
		mean_result_t res;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, wt, sc};
		s_tuser  <= ok;
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
		n_requests++;
		take_term(sc, wt, ok, lst, has_res, res);
		if (has_res) begin
			if (typed) begin
				res.mu = tmu;
				res.go = tgo;
			end
			means_due.push_back(res);
		end
	endtask

	// One random set: mostly well-formed sets within the term limit, with
	// some over-long ones; scores lean toward 1.0 so that mu stays readable.
	task automatic send_random_set(output int n);
		int          pick, wclass;
		logic [16:0] sc;
		logic [15:0] wt;
		pick = $urandom_range(99);
		if (pick < 80) n = $urandom_range(1, 8);
		else if (pick < 95) n = $urandom_range(9, TERM_LIMIT);
		else n = $urandom_range(TERM_LIMIT + 1, TERM_LIMIT + 4);
		wclass = $urandom_range(99);
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 60) sc = 17'(65536 - $urandom_range(0, 16383));
			else if (pick < 80) sc = 17'($urandom_range(0, 131071));
			else if (pick < 90) sc = 17'($urandom_range(0, 255));
			else sc = ($urandom_range(1)) ? 17'd65536 : 17'd131071;
			if (wclass < 50) wt = 16'($urandom_range(0, 4095));
			else if (wclass < 60) wt = 16'd0;
			else wt = 16'($urandom_range(0, 65535));
			offer(sc, wt, ($urandom_range(99) < 75), (k == n - 1), 1'b0, '0, 1'b0);
		end
		n_sets++;
	endtask

	// Let every pending result arrive and the block fall idle.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (means_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		longint unsigned x, lr, root, prod, v, sq, c;
		logic [16:0]     thr;
		int              phase_items, n;

		// Fraction tables: log2(1 + i/256) by repeated squaring, 2^(i/256) from
		// a product of successive square roots of two.
		for (int i = 0; i < 256; i++) begin
			x  = 64'(256 + i) << 22;
			lr = 0;
			for (int k = 0; k < 24; k++) begin
				x = (x * x) >> 30;
				if (x >= (64'd1 << 31)) begin
					lr = (lr << 1) | 1;
					x  = x >> 1;
				end else begin
					lr = lr << 1;
				end
			end
			log_frac[i] = 17'((lr + 128) >> 8);
			root = 64'd2 << 30;
			prod = 64'd1 << 30;
			for (int k = 7; k >= 0; k--) begin
				v  = root << 30;
				sq = 0;
				for (int b = 31; b >= 0; b--) begin
					c = sq | (64'd1 << b);
					if (c * c <= v) sq = c;
				end
				root = sq;
				if (((i >> k) & 1) != 0) prod = (prod * root) >> 30;
			end
			pow_frac[i] = 17'((prod + (64'd1 << 13)) >> 14);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (dir_rows[i]) begin
			repeat (dir_rows[i].rep) begin
				offer(dir_rows[i].score, dir_rows[i].weight, dir_rows[i].ok, dir_rows[i].last,
					dir_rows[i].typed, dir_rows[i].mu, dir_rows[i].go);
			end
		end

		// Random phases, each under its own threshold and idle pattern.
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			wait_drained();
			case (ph)
				0: thr = 17'(THR_AT_RESET);
				1: thr = 17'd0;
				2: thr = 17'd65536;
				3: thr = 17'd65537;
				4: thr = 17'd131071;
				5: thr = 17'($urandom_range(0, 65536));
				default: thr = 17'($urandom_range(60000, 65536));
			endcase
			cfg_wen   <= 1'b1;
			cfg_wdata <= thr;
			@(posedge clk);
			cfg_wen <= 1'b0;
			go_thr  = thr;

			case (ph % 4)
				0: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct   = 64;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct   = 0;
					sink_stall_pct = 64;
				end
				default: begin
					src_idle_pct   = 9;
					sink_stall_pct = 9;
				end
			endcase

			// Back pressure: hold the result side off while requests keep coming.
			if (ph == 4) begin
				hold_req_cycles <= LONG_HOLD;
				hold_req_seq    <= hold_req_seq + 1;
			end

			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				send_random_set(n);
				phase_items += n;
			end
		end

		wait_drained();
		if (means_due.size() != 0) begin
			$error("%0d results never arrived", means_due.size());
			fail_cnt++;
		end
		$display("Covered %0d requests in %0d random sets plus the directed table, %0d results.",
			n_requests, n_sets, n_results);
		$display("Thresholds swept from 0 through 1.0 to the register maximum, under four idle patterns.");
		if (fail_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
